// ===== rtl/rrq_pkg.sv =====
// ----------------------------------------------------------------------------
// rrq_pkg
// shared types, codes and helpers for the reservation ring queue unit
// ----------------------------------------------------------------------------
`default_nettype none

package rrq_pkg;

  localparam int DATA_W  = 32;
  localparam int OFS_W   = 32;
  localparam int COUNT_W = 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index taken from paddr[2]
  localparam logic REG_PRODUCER_COUNT = 1'b0;
  localparam logic REG_CONSUMER_COUNT = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;

  typedef enum logic [1:0] {
    CMD_RESV_PUSH    = 2'd0,
    CMD_COMMIT_PUSH  = 2'd1,
    CMD_RESV_POP     = 2'd2,
    CMD_COMPLETE_POP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_WAIT     = 3'd1,
    ST_NO_RESV  = 3'd2,
    ST_ALREADY  = 3'd3,
    ST_BAD_PORT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    reserve;
    logic    scan_init;
    logic    scan_step;
    logic    mem_write;
    logic    mem_read;
    logic    free_resv;
    logic    finish;
    status_t fin_status;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic port_bad;
    logic is_reserve;
    logic is_push;
    logic own_valid;
    logic scan_last;
    logic fits;
  } ctl_sts_t;

  // wrapping order: a lies before b
  function automatic logic ofs_before(input logic [OFS_W-1:0] a,
                                      input logic [OFS_W-1:0] b);
    logic [OFS_W-1:0] diff;
    diff = a - b;
    return diff[OFS_W-1];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rrq_ram.sv =====
// ----------------------------------------------------------------------------
// rrq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrq_ctrl
// command sequencer: check, oldest-reservation scan, decide, slot read
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire rrq_pkg::ctl_sts_t sts,
  output rrq_pkg::ctl_cmd_t      ctl
);
  import rrq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl            = '0;
    ctl.fin_status = ST_OK;
    busy           = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.port_bad) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_BAD_PORT;
          state_next     = S_IDLE;
        end else if (sts.is_reserve) begin
          ctl.finish = 1'b1;
          if (sts.own_valid) begin
            ctl.fin_status = ST_ALREADY;
          end else begin
            ctl.reserve    = 1'b1;
            ctl.fin_status = ST_OK;
          end
          state_next = S_IDLE;
        end else if (!sts.own_valid) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_NO_RESV;
          state_next     = S_IDLE;
        end else begin
          ctl.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.fits) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_WAIT;
          state_next     = S_IDLE;
        end else if (sts.is_push) begin
          ctl.mem_write  = 1'b1;
          ctl.free_resv  = 1'b1;
          ctl.finish     = 1'b1;
          ctl.fin_status = ST_OK;
          state_next     = S_IDLE;
        end else begin
          ctl.mem_read  = 1'b1;
          ctl.free_resv = 1'b1;
          state_next    = S_READ;
        end
      end
      S_READ: begin
        ctl.finish     = 1'b1;
        ctl.fin_status = ST_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rrq_datapath.sv =====
// ----------------------------------------------------------------------------
// rrq_datapath
// reservation tables, offset counters, minimum scan, slot ram, result registers
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_datapath #(
  parameter int DEPTH     = 1024,
  parameter int MAX_PORTS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    cmd,
  input  wire logic [1:0]                    port,
  input  wire logic [rrq_pkg::DATA_W-1:0]    push_data,
  input  wire logic [rrq_pkg::COUNT_W-1:0]   producer_count,
  input  wire logic [rrq_pkg::COUNT_W-1:0]   consumer_count,
  input  wire rrq_pkg::ctl_cmd_t             ctl,
  output rrq_pkg::ctl_sts_t                  sts,
  output logic                               done,
  output logic [2:0]                         status,
  output logic [rrq_pkg::OFS_W-1:0]          slot_offset,
  output logic [rrq_pkg::DATA_W-1:0]         pop_data
);
  import rrq_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PIDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int TAB_N  = 2 ** PIDX_W;
  localparam int USED_W = ($clog2(MAX_PORTS + 1) > COUNT_W) ? $clog2(MAX_PORTS + 1) : COUNT_W;

  // captured command
  cmd_t               cmd_q;
  logic [1:0]         port_q;
  logic [DATA_W-1:0]  data_q;

  // reservation tables
  logic [OFS_W-1:0]   wr_ofs  [TAB_N];
  logic [ADDR_W-1:0]  wr_slot [TAB_N];
  logic [TAB_N-1:0]   wr_valid;
  logic [OFS_W-1:0]   rd_ofs  [TAB_N];
  logic [ADDR_W-1:0]  rd_slot [TAB_N];
  logic [TAB_N-1:0]   rd_valid;

  // offset counters with their slot index kept alongside
  logic [OFS_W-1:0]   next_wr, next_rd;
  logic [ADDR_W-1:0]  slot_wr, slot_rd;

  // scan
  logic [OFS_W-1:0]   min_ofs;
  logic [PIDX_W-1:0]  idx;

  logic               is_push, is_reserve;
  logic [PIDX_W-1:0]  own_idx, wr_addr, rd_addr;
  logic [USED_W-1:0]  prod_used, cons_used, own_used, oth_used;
  logic [OFS_W-1:0]   own_ofs, oth_ofs, next_own, next_inc, ahead;
  logic [ADDR_W-1:0]  own_slot, slot_own, slot_inc;
  logic               own_valid, oth_valid, fits, take;
  logic [DATA_W-1:0]  rdata;

  assign is_push    = (cmd_q == CMD_RESV_PUSH) || (cmd_q == CMD_COMMIT_PUSH);
  assign is_reserve = (cmd_q == CMD_RESV_PUSH) || (cmd_q == CMD_RESV_POP);
  assign own_idx    = PIDX_W'(port_q);

  // each table has one read address: the issuing port or the scan index
  assign wr_addr = is_push ? own_idx : idx;
  assign rd_addr = is_push ? idx : own_idx;

  assign prod_used = (USED_W'(producer_count) > USED_W'(MAX_PORTS)) ?
                     USED_W'(MAX_PORTS) : USED_W'(producer_count);
  assign cons_used = (USED_W'(consumer_count) > USED_W'(MAX_PORTS)) ?
                     USED_W'(MAX_PORTS) : USED_W'(consumer_count);
  assign own_used  = is_push ? prod_used : cons_used;
  assign oth_used  = is_push ? cons_used : prod_used;

  assign own_ofs   = is_push ? wr_ofs[wr_addr]   : rd_ofs[rd_addr];
  assign own_slot  = is_push ? wr_slot[wr_addr]  : rd_slot[rd_addr];
  assign own_valid = is_push ? wr_valid[wr_addr] : rd_valid[rd_addr];
  assign oth_ofs   = is_push ? rd_ofs[rd_addr]   : wr_ofs[wr_addr];
  assign oth_valid = is_push ? rd_valid[rd_addr] : wr_valid[wr_addr];

  assign next_own = is_push ? next_wr : next_rd;
  assign slot_own = is_push ? slot_wr : slot_rd;
  assign next_inc = next_own + OFS_W'(1);
  // slot index restarts with the offset when the offset wraps
  assign slot_inc = (next_inc == '0) ? '0 :
                    (slot_own == ADDR_W'(DEPTH - 1)) ? '0 : slot_own + ADDR_W'(1);

  assign take = (USED_W'(idx) < oth_used) && oth_valid && ofs_before(oth_ofs, min_ofs);

  assign ahead = own_ofs - min_ofs;
  assign fits  = is_push ? (ahead[OFS_W-1] || (ahead < OFS_W'(DEPTH)))
                         : ofs_before(own_ofs, min_ofs);

  always_comb begin
    sts.port_bad   = (USED_W'(port_q) >= own_used);
    sts.is_reserve = is_reserve;
    sts.is_push    = is_push;
    sts.own_valid  = own_valid;
    sts.scan_last  = (idx == PIDX_W'(MAX_PORTS - 1));
    sts.fits       = fits;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= '0;
      rd_valid <= '0;
      next_wr  <= '0;
      next_rd  <= '0;
      slot_wr  <= '0;
      slot_rd  <= '0;
      done     <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.reserve) begin
        if (is_push) begin
          wr_valid[own_idx] <= 1'b1;
          next_wr           <= next_inc;
          slot_wr           <= slot_inc;
        end else begin
          rd_valid[own_idx] <= 1'b1;
          next_rd           <= next_inc;
          slot_rd           <= slot_inc;
        end
      end
      if (ctl.free_resv) begin
        if (is_push) begin
          wr_valid[own_idx] <= 1'b0;
        end else begin
          rd_valid[own_idx] <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= cmd_t'(cmd);
      port_q <= port;
      data_q <= push_data;
    end
    if (ctl.reserve) begin
      if (is_push) begin
        wr_ofs[own_idx]  <= next_wr;
        wr_slot[own_idx] <= slot_wr;
      end else begin
        rd_ofs[own_idx]  <= next_rd;
        rd_slot[own_idx] <= slot_rd;
      end
    end
    if (ctl.scan_init) begin
      min_ofs <= is_push ? next_rd : next_wr;
      idx     <= '0;
    end else if (ctl.scan_step) begin
      if (take) begin
        min_ofs <= oth_ofs;
      end
      idx <= idx + PIDX_W'(1);
    end
    if (ctl.finish) begin
      status <= ctl.fin_status;
      if ((ctl.fin_status == ST_BAD_PORT) || (ctl.fin_status == ST_NO_RESV)) begin
        slot_offset <= '0;
      end else if (is_reserve && (ctl.fin_status == ST_OK)) begin
        slot_offset <= next_own;
      end else begin
        slot_offset <= own_ofs;
      end
      if ((ctl.fin_status == ST_OK) && (cmd_q == CMD_COMPLETE_POP)) begin
        pop_data <= rdata;
      end else begin
        pop_data <= '0;
      end
    end
  end

  rrq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ctl.mem_write),
    .waddr (own_slot),
    .wdata (data_q),
    .re    (ctl.mem_read),
    .raddr (own_slot),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/reservation_ring_queue_unit.sv =====
// ----------------------------------------------------------------------------
// reservation_ring_queue_unit
// multi-port ring queue: ports reserve slot offsets, then commit or complete
// ----------------------------------------------------------------------------
//
//  channel   handshake                      payload
//  -------   -----------------------------  ---------------------------------
//  command   start / busy, taken start&!busy cmd, port, push_data
//  result    done strobe, one cycle, no stall status, slot_offset, pop_data
//  config    apb write, psel&penable&pwrite  paddr, pwdata (prdata on read)
//
//  reserve push/pop and every error answer finish in the check step that
//  follows the taken command. commit push with a reservation and complete
//  pop go on through the oldest-reservation scan, one port per cycle, and a
//  decide step; a complete pop that reads its slot then adds the registered
//  read of the slot ram.
//  result is registered and shown the cycle after the decision; a new command
//  can be taken in that same cycle. reset clears the reservation valid bits,
//  both offset counters and the port counts (2 each); slot ram is not cleared.
//
// ----------------------------------------------------------------------------
`default_nettype none

module reservation_ring_queue_unit #(
  parameter int DEPTH     = 1024,
  parameter int MAX_PORTS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    cmd,
  input  wire logic [1:0]                    port,
  input  wire logic [rrq_pkg::DATA_W-1:0]    push_data,
  // result
  output logic                               done,
  output logic [2:0]                         status,
  output logic [rrq_pkg::OFS_W-1:0]          slot_offset,
  output logic [rrq_pkg::DATA_W-1:0]         pop_data,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrq_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rrq_pkg::PDATA_W-1:0]   pwdata,
  output logic      [rrq_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import rrq_pkg::*;

  logic [COUNT_W-1:0] producer_count;
  logic [COUNT_W-1:0] consumer_count;
  logic               cfg_write;
  logic               reg_sel;
  ctl_cmd_t           ctl;
  ctl_sts_t           sts;

  // register file: producer count at 0x0, consumer count at 0x4
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      producer_count <= COUNT_RESET;
      consumer_count <= COUNT_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_PRODUCER_COUNT) begin
        producer_count <= pwdata[COUNT_W-1:0];
      end else begin
        consumer_count <= pwdata[COUNT_W-1:0];
      end
    end
  end

  // read back, zero above the count bits
  always_comb begin
    if (reg_sel == REG_PRODUCER_COUNT) begin
      prdata = PDATA_W'(producer_count);
    end else begin
      prdata = PDATA_W'(consumer_count);
    end
  end

  // sequencer: owns busy and steps the datapath
  rrq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // tables, counters, scan and slot store
  rrq_datapath #(
    .DEPTH     (DEPTH),
    .MAX_PORTS (MAX_PORTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .port           (port),
    .push_data      (push_data),
    .producer_count (producer_count),
    .consumer_count (consumer_count),
    .ctl            (ctl),
    .sts            (sts),
    .done           (done),
    .status         (status),
    .slot_offset    (slot_offset),
    .pop_data       (pop_data)
  );

endmodule

`default_nettype wire

// ===== rtl/rrq_checker.sv =====
// ----------------------------------------------------------------------------
// rrq_checker
// port-level checks on the reservation ring queue unit
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [2:0]                  status,
  input wire logic [rrq_pkg::OFS_W-1:0]   slot_offset,
  input wire logic [rrq_pkg::DATA_W-1:0]  pop_data
);
  import rrq_pkg::*;

  // a taken command makes the unit busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but unit not busy");

  // results only come out of a command in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in progress");

  // bad-port and no-reservation answers carry no offset
  a_err_offset: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == ST_BAD_PORT) || (status == ST_NO_RESV))) |-> (slot_offset == '0))
    else $error("offset on an error answer");

  // data only on a good answer
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (pop_data == '0))
    else $error("pop data on a failed answer");

endmodule

bind reservation_ring_queue_unit rrq_checker u_rrq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .slot_offset (slot_offset),
  .pop_data    (pop_data)
);

`default_nettype wire
